/* hw/rtl/prescaled_radix10_divider_defines.svh */
// assertion macros shared by the divider checker
`ifndef PRESCALED_RADIX10_DIVIDER_DEFINES_SVH
`define PRESCALED_RADIX10_DIVIDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication with a fixed delay, disabled during reset
`define PRD_ASSERT_AFTER(label, clk, rst, ante, lat, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(lat) (cons)) \
      else $error(msg);

`endif

/* hw/rtl/prd_pkg.sv */
// package for the prescaled radix-10 divider: widths, word types, reciprocal table
`default_nettype none

package prd_pkg;

   localparam int OP_W           = 32;
   localparam int FRAC_BITS      = 32;
   localparam int TABLE_BITS     = 8;
   localparam int ITERATIONS_DEF = 8;
   localparam int QUOT_W         = 28;

   localparam int KEY_SHIFT = FRAC_BITS - TABLE_BITS;
   localparam int HALF_KEYS = 2 ** (TABLE_BITS - 1);
   localparam int KEY_IDX_W = TABLE_BITS - 1;
   localparam int RECIP_W   = TABLE_BITS + 2;
   localparam int PROD_W    = FRAC_BITS + RECIP_W;
   localparam int RES_FRAC  = FRAC_BITS + TABLE_BITS;
   localparam int DIG_W     = 8;
   localparam int RES_W     = RES_FRAC + DIG_W;

   localparam int unsigned KEY_NUM = 2 ** (2 * TABLE_BITS);

   typedef struct packed {
      logic [OP_W-1:0] dividend;
      logic [OP_W-1:0] divisor;
   } req_word_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quotient_scaled;
      logic              bad_input;
   } rsp_word_type;

   typedef logic [HALF_KEYS-1:0][RECIP_W-1:0] recip_rom_type;

   // smallest q with q*m >= 2^(2*TABLE_BITS) for keys m in [HALF_KEYS, 2*HALF_KEYS)
   function automatic recip_rom_type build_recip_rom();
      recip_rom_type rom;
      int unsigned   m;
      int unsigned   num;
      int unsigned   q;
      rom = '0;
      for (int k = 0; k < HALF_KEYS; k++) begin
         m   = HALF_KEYS + k;
         num = KEY_NUM + m - 1;
         q   = 0;
         for (int b = RECIP_W - 1; b >= 0; b--) begin
            if ((q + (1 << b)) * m <= num) q = q + (1 << b);
         end
         rom[k] = RECIP_W'(q);
      end
      return rom;
   endfunction

   localparam recip_rom_type RECIP_ROM = build_recip_rom();

endpackage

`default_nettype wire

/* hw/rtl/prescaled_radix10_divider.sv */
// prescaled radix-10 divider, one operand word per cycle, fully pipelined
//
// Takes one word per cycle whenever start is high and busy is low; busy is
// high only while reset is asserted. Each word comes out on rsp_data, marked
// by rsp_valid for exactly one cycle; the receiver cannot stall. The pipeline
// registers are, in order: key rounding and reciprocal lookup, operand
// prescaling, for each quotient digit a digit select by rounding and then the
// residual update multiply, and the output register.
`default_nettype none

module prescaled_radix10_divider
   import prd_pkg::*;
#(
   parameter int ITERATIONS = ITERATIONS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   output rsp_word_type      rsp_data
);

   localparam logic [KEY_SHIFT-1:0] KEY_HALF = {1'b1, {(KEY_SHIFT-1){1'b0}}};
   localparam logic [RES_W-1:0] ROUND_HALF =
      {{(RES_W-RES_FRAC){1'b0}}, 1'b1, {(RES_FRAC-1){1'b0}}};

   // key select and reciprocal lookup
   logic [TABLE_BITS-1:0] key_base;
   logic                  key_round_up;
   logic [TABLE_BITS:0]   key_sum;
   logic [KEY_IDX_W-1:0]  key_idx;
   logic                  bad_in;

   logic [OP_W-1:0]    x_ff;
   logic [OP_W-1:0]    d_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic               bad0_ff;
   logic               vld0_ff;

   // prescale
   logic [PROD_W-1:0] xp_in;
   logic [PROD_W-1:0] dp_in;

   // digit pipeline
   logic signed [RES_W-1:0] w_ff    [ITERATIONS];
   logic [PROD_W-1:0]       dp_ff   [ITERATIONS];
   logic [QUOT_W-1:0]       q_ff    [ITERATIONS+1];
   logic                    bad_ff  [ITERATIONS+1];
   logic                    vld_ff  [ITERATIONS+1];

   logic signed [RES_W-1:0] t_ff    [ITERATIONS];
   logic signed [DIG_W-1:0] dig_ff  [ITERATIONS];
   logic [PROD_W-1:0]       dpa_ff  [ITERATIONS];
   logic [QUOT_W-1:0]       qa_ff   [ITERATIONS];
   logic                    bada_ff [ITERATIONS];
   logic                    vlda_ff [ITERATIONS];

   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   assign busy = reset;

   always_comb begin
      key_base     = req_data.divisor[FRAC_BITS-1 -: TABLE_BITS];
      key_round_up = req_data.divisor[KEY_SHIFT-1:0] > KEY_HALF;
      key_sum      = {1'b0, key_base} + {{TABLE_BITS{1'b0}}, key_round_up};
      key_idx      = key_sum[TABLE_BITS] ? {KEY_IDX_W{1'b1}} : key_sum[KEY_IDX_W-1:0];
      bad_in       = !req_data.dividend[FRAC_BITS-1] || !req_data.divisor[FRAC_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= req_data.dividend;
      d_ff     <= req_data.divisor;
      recip_ff <= RECIP_ROM[key_idx];
      bad0_ff  <= bad_in;
   end

   always_comb begin
      xp_in = x_ff * recip_ff;
      dp_in = d_ff * recip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_ff[0]   <= {{(RES_W-PROD_W){1'b0}}, xp_in};
      dp_ff[0]  <= dp_in;
      q_ff[0]   <= '0;
      bad_ff[0] <= bad0_ff;
   end

   genvar gi;
   for (gi = 0; gi < ITERATIONS; gi++) begin : g_digit
      logic signed [RES_W-1:0]       t_in;
      logic signed [RES_W-1:0]       rnd_sum;
      logic signed [DIG_W-1:0]       dig_in;
      logic signed [PROD_W+DIG_W:0]  prod;
      logic signed [RES_W-1:0]       w_in;
      logic [QUOT_W-1:0]             q_in;

      // digit select: round 10*w half away from zero
      always_comb begin
         t_in    = (w_ff[gi] <<< 3) + (w_ff[gi] <<< 1);
         rnd_sum = t_in + ROUND_HALF - {{(RES_W-1){1'b0}}, t_in[RES_W-1]};
         dig_in  = rnd_sum[RES_FRAC +: DIG_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vlda_ff[gi] <= 1'b0;
         end else begin
            vlda_ff[gi] <= vld_ff[gi];
         end
      end

      always_ff @(posedge clock) begin
         t_ff[gi]    <= t_in;
         dig_ff[gi]  <= dig_in;
         dpa_ff[gi]  <= dp_ff[gi];
         qa_ff[gi]   <= q_ff[gi];
         bada_ff[gi] <= bad_ff[gi];
      end

      // residual update and quotient accumulate
      always_comb begin
         prod = $signed({1'b0, dpa_ff[gi]}) * dig_ff[gi];
         w_in = t_ff[gi] - prod[RES_W-1:0];
         q_in = (qa_ff[gi] << 3) + (qa_ff[gi] << 1) + QUOT_W'(dig_ff[gi]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[gi+1] <= 1'b0;
         end else begin
            vld_ff[gi+1] <= vlda_ff[gi];
         end
      end

      always_ff @(posedge clock) begin
         q_ff[gi+1]   <= q_in;
         bad_ff[gi+1] <= bada_ff[gi];
      end

      if (gi < ITERATIONS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            w_ff[gi+1]  <= w_in;
            dp_ff[gi+1] <= dpa_ff[gi];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.quotient_scaled <= bad_ff[ITERATIONS] ? '0 : q_ff[ITERATIONS];
      rsp_data_ff.bad_input       <= bad_ff[ITERATIONS];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/prd_checker.sv */
// port-level checker for the prescaled radix-10 divider, with its bind
`default_nettype none
`include "prescaled_radix10_divider_defines.svh"

module prd_checker
   import prd_pkg::*;
#(
   parameter int ITERATIONS = ITERATIONS_DEF
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire req_word_type req_data,
   input wire logic         rsp_valid,
   input wire rsp_word_type rsp_data
);

   localparam int LAT = 2 * ITERATIONS + 3;

   logic word_in;
   logic op_low;

   assign word_in = start && !busy;
   assign op_low  = !req_data.dividend[FRAC_BITS-1] || !req_data.divisor[FRAC_BITS-1];

   `PRD_ASSERT_AFTER(a_word_comes_out, clock, reset, word_in, LAT, rsp_valid, "word lost")
   `PRD_ASSERT_NOW(a_no_extra_word, clock, reset, rsp_valid, $past(word_in, LAT), "extra word")
   `PRD_ASSERT_AFTER(a_bad_flagged, clock, reset, word_in && op_low, LAT,
      rsp_data.bad_input, "low operand not flagged")
   `PRD_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid && rsp_data.bad_input,
      rsp_data.quotient_scaled == '0, "nonzero quotient on bad input")

endmodule

bind prescaled_radix10_divider prd_checker #(.ITERATIONS(ITERATIONS)) u_prd_checker (.*);

`default_nettype wire

/* dv/tb_prescaled_radix10_divider.sv */
// self-checking testbench for the prescaled radix-10 divider
`default_nettype none

module tb_prescaled_radix10_divider
   import prd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DIGITS       = ITERATIONS_DEF;
   localparam int          LATENCY      = 2 * DIGITS + 3;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_WORDS = 1250;
   localparam logic [63:0] HALF_OPERAND = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] LAST_KEY     = (64'd1 << TABLE_BITS) - 64'd1;
   localparam logic [31:0] OP_HALF      = 32'h8000_0000;
   localparam logic [31:0] OP_MAX       = 32'hFFFF_FFFF;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_data;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   rsp_word_type expected_quotients[$];
   int           error_count;
   int           words_sent;
   int           bad_words_sent;
   int           quotients_checked;
   int           cycle_count;
   int           burst_left;

   prescaled_radix10_divider dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_word_type predict_quotient(req_word_type w);
      logic [63:0]  xv, dv, key, rem, recip, xp, dp, res, t, mag, dig, quot, weight;
      rsp_word_type r;
      xv = 64'(w.dividend);
      dv = 64'(w.divisor);
      r  = '0;
      if (xv < HALF_OPERAND || dv < HALF_OPERAND) begin
         r.bad_input = 1'b1;
         return r;
      end
      key = dv >> KEY_SHIFT;
      rem = dv & ((64'd1 << KEY_SHIFT) - 64'd1);
      if (rem > (64'd1 << (KEY_SHIFT - 1))) key = key + 64'd1;
      if (key > LAST_KEY) key = LAST_KEY;
      recip  = ((64'd1 << (2 * TABLE_BITS)) + key - 64'd1) / key;
      xp     = xv * recip;
      dp     = dv * recip;
      weight = 64'd1;
      for (int i = 1; i < DIGITS; i++) weight = weight * 64'd10;
      res  = xp;
      quot = 64'd0;
      for (int i = 1; i <= DIGITS; i++) begin
         t   = res * 64'd10;
         mag = t[63] ? 64'd0 - t : t;
         dig = (mag + (64'd1 << (RES_FRAC - 1))) >> RES_FRAC;
         if (t[63]) dig = 64'd0 - dig;
         quot   = quot + dig * weight;
         res    = t - dp * dig;
         weight = weight / 64'd10;
      end
      r.quotient_scaled = quot[QUOT_W-1:0];
      return r;
   endfunction

   // caller is at a falling edge; returns at a falling edge, with start low after a gap only at the end of a burst
   task automatic send_word(input logic [31:0] dividend, input logic [31:0] divisor);
      req_word_type w;
      w.dividend = dividend;
      w.divisor  = divisor;
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_quotients.push_back(predict_quotient(w));
      words_sent++;
      if (dividend < OP_HALF || divisor < OP_HALF) bad_words_sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      @(negedge clock);
      while (expected_quotients.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] valid_operand();
      return {1'b1, 31'($urandom())};
   endfunction

   task automatic test_operand_extremes();
      send_word(OP_HALF, OP_HALF);
      send_word(OP_MAX, OP_MAX);
      send_word(OP_MAX, OP_HALF);
      send_word(OP_HALF, OP_MAX);
      send_word(32'hAAAA_AAAA, 32'hD555_5555);
      send_word(32'hF000_0000, 32'h8000_0001);
   endtask

   task automatic test_invalid_operands();
      send_word(32'h7FFF_FFFF, OP_HALF);
      send_word(OP_HALF, 32'h7FFF_FFFF);
      send_word(32'h0000_0000, 32'h0000_0000);
      send_word(OP_MAX, 32'h0000_0000);
      send_word(32'h0000_0001, OP_MAX);
   endtask

   // divisor on, just above and just below a midpoint between keys, and past the last key
   task automatic test_key_rounding();
      send_word(32'hC000_0000, 32'hC080_0000);
      send_word(32'hC000_0000, 32'hC080_0001);
      send_word(32'hC000_0000, 32'hC07F_FFFF);
      send_word(32'h8000_0000, 32'h8080_0000);
      send_word(32'hFFFF_FFFF, 32'h8080_0001);
      send_word(32'h9000_0000, 32'hFF80_0000);
      send_word(32'h9000_0000, 32'hFF80_0001);
      send_word(32'hE000_0000, 32'hFFC0_0000);
   endtask

   task automatic test_drain_pause();
      repeat (10) send_word(valid_operand(), valid_operand());
      wait_for_drain();
      repeat (10) send_word(valid_operand(), valid_operand());
   endtask

   task automatic test_random_operands(input int count);
      logic [31:0] x, d;
      for (int n = 0; n < count; n++) begin
         x = valid_operand();
         d = valid_operand();
         case ($urandom_range(0, 9))
            0: d = {1'b1, 7'($urandom()), 24'h80_0000};
            1: d = {1'b1, 7'($urandom()), 24'h80_0000 + 24'($urandom_range(0, 2)) - 24'd1};
            2: d = {9'h1FF, 23'($urandom())};
            3: x = $urandom() & 32'h7FFF_FFFF;
            4: d = $urandom() & 32'h7FFF_FFFF;
            5: begin
               x = $urandom();
               d = $urandom();
            end
            default: ;
         endcase
         send_word(x, d);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_quotients.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, actual quotient %0d bad %0b", $time,
                     rsp_data.quotient_scaled, rsp_data.bad_input);
         end else begin
            exp_word = expected_quotients.pop_front();
            quotients_checked++;
            if (rsp_data.quotient_scaled !== exp_word.quotient_scaled) begin
               error_count++;
               $display("%0t: quotient mismatch, expected %0d actual %0d", $time,
                        exp_word.quotient_scaled, rsp_data.quotient_scaled);
            end
            if (rsp_data.bad_input !== exp_word.bad_input) begin
               error_count++;
               $display("%0t: bad_input mismatch, expected %0b actual %0b", $time,
                        exp_word.bad_input, rsp_data.bad_input);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, expected_quotients.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      error_count       = 0;
      words_sent        = 0;
      bad_words_sent    = 0;
      quotients_checked = 0;
      cycle_count       = 0;
      burst_left        = 8;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_operand_extremes();
      test_invalid_operands();
      test_key_rounding();
      test_drain_pause();
      test_random_operands(RANDOM_WORDS);

      wait_for_drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (expected_quotients.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected words never arrived", $time, expected_quotients.size());
      end
      $display("covered %0d operand words (%0d with an operand below one half), %0d checked",
               words_sent, bad_words_sent, quotients_checked);
      $display("including key midpoints, divisors past the last key and a full drain pause");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/prd_pkg.sv
hw/rtl/prescaled_radix10_divider.sv
hw/rtl/prd_checker.sv
dv/tb_prescaled_radix10_divider.sv
